FILE: design/scar_pkg.sv
`timescale 1ns / 1ps
package scar_pkg;

  localparam int GEOM_W   = 49;
  localparam int ROW_W    = 32;
  localparam int RSTART_W = 36;
  localparam int OFFS_W   = 37;
  localparam int CRD_W    = 10;
  localparam int NPTS     = 7;

  localparam logic [1:0] REG_AXIS_X = 2'd0;
  localparam logic [1:0] REG_AXIS_Y = 2'd1;
  localparam logic [1:0] REG_AXIS_Z = 2'd2;
  localparam logic [1:0] REG_BLOCK  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NBR,
    ST_SORT,
    ST_EMIT
  } state_t;

  // Signed stencil offsets in model order.
  function automatic logic signed [2:0] nbr_delta(input logic [2:0] s, input logic [1:0] a);
    logic signed [2:0] d;
    d = 3'sd0;
    case (s)
      3'd0: if (a == 2'd2) d = -3'sd1;
      3'd1: if (a == 2'd1) d = -3'sd1;
      3'd2: if (a == 2'd0) d = -3'sd1;
      3'd4: if (a == 2'd0) d = 3'sd1;
      3'd5: if (a == 2'd1) d = 3'sd1;
      3'd6: if (a == 2'd2) d = 3'sd1;
      default: d = 3'sd0;
    endcase
    return d;
  endfunction

endpackage

FILE: design/scar_point.sv
`timescale 1ns / 1ps
// Evaluates one stencil point: wrap, on-grid test, per-axis offset outside
// the owned box. Combinational; the sequencer registers the results.
// Selection 7 is the vertex itself, taken as given and never wrapped.
module scar_point import scar_pkg::*; #(
  parameter int SH_W = 11,
  parameter int P_W  = 11
) (
  input  logic [SH_W-1:0]   sh [3],
  input  logic [15:0]       st [3],
  input  logic [15:0]       wd [3],
  input  logic [2:0]        wr,
  input  logic [CRD_W-1:0]  vp [3],
  input  logic [2:0]        sel,
  output logic              ok,
  output logic signed [19:0] off [3],
  output logic [P_W-1:0]    p [3]
);

  always_comb begin
    logic signed [19:0] q, lo, hi, s;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      s  = 20'(signed'({1'b0, sh[a]}));
      q  = 20'(signed'({1'b0, vp[a]})) + 20'(nbr_delta(sel, 2'(a)));
      if (wr[a] && sel != 3'd7) begin
        if (q < 0) q = q + s;
        else if (q >= s) q = q - s;
      end
      if (q < 0 || q >= s) ok = 1'b0;
      lo = 20'(signed'({1'b0, st[a]}));
      hi = lo + 20'(signed'({1'b0, wd[a]})) - 20'sd1;
      off[a] = 20'sd0;
      if (q < lo) off[a] = q - lo;
      if (q > hi) off[a] = q - hi;
      p[a] = q[P_W-1:0];
    end
  end

endmodule

FILE: design/stencil_color_adjacency_rows_core.sv
`timescale 1ns / 1ps
// Sequence: the vertex is taken while idle, then one shared multiply-add unit runs
// 4 steps each for the vertex itself and the 7 stencil points, then 7 sort
// passes, then one result per cycle while out_ready is high, up to 63 results.
// in_ready is high only while idle, so a new vertex waits until all results of the
// previous one are out.
// Reset (synchronous, rst_n low) restores default geometry, block_size 1,
// clears the running offset and idles the sequencer.
module stencil_color_adjacency_rows_core import scar_pkg::*; #(
  parameter int AXIS_MAX = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [GEOM_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CRD_W-1:0]    in_vertex_x,
  input  logic [CRD_W-1:0]    in_vertex_y,
  input  logic [CRD_W-1:0]    in_vertex_z,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ROW_W-1:0]    out_row,
  output logic [RSTART_W-1:0] out_row_start,
  output logic [ROW_W-1:0]    out_column,
  output logic                out_last_in_row,
  output logic                out_last
);

  localparam int SH_W = $clog2(AXIS_MAX + 1);
  localparam int P_W  = (SH_W > CRD_W) ? SH_W : CRD_W;
  localparam logic [15:0] AXMAX16 = 16'(AXIS_MAX);

  // Configuration registers.
  logic [GEOM_W-1:0] geo_r [3];
  logic [1:0]        bs_r;
  logic [OFFS_W-1:0] offs_r, offs_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) geo_r[a] <= GEOM_W'(64'd4294967297);
      bs_r <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AXIS_X: geo_r[0] <= cfg_data;
        REG_AXIS_Y: geo_r[1] <= cfg_data;
        REG_AXIS_Z: geo_r[2] <= cfg_data;
        REG_BLOCK:  bs_r     <= cfg_data[1:0];
        default:    bs_r     <= bs_r;
      endcase
    end
  end

  logic [SH_W-1:0] sh [3];
  logic [15:0]     st [3], wd [3];
  logic [2:0]      wr;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sh[a] = (geo_r[a][15:0] > AXMAX16) ? SH_W'(AXIS_MAX) : geo_r[a][SH_W-1:0];
      st[a] = geo_r[a][31:16];
      wd[a] = geo_r[a][47:32];
      wr[a] = geo_r[a][48];
    end
  end

  // Sequencer state.
  state_t          state_r, state_nxt;
  logic [CRD_W-1:0] vp_r [3];
  logic [2:0]      pt_r, pt_nxt;     // stencil point, 7 = vertex itself for colour
  logic [1:0]      ph_r, ph_nxt;     // step within a point
  logic signed [49:0] acc_r, acc_nxt;
  logic signed [49:0] col_r, col_nxt;
  logic signed [49:0] vcol_r, vcol_nxt;
  logic [47:0]     idx_r, idx_nxt;
  logic            ok_r, ok_nxt;
  logic [47:0]     kept_r [NPTS];
  logic [2:0]      nk_r, nk_nxt;
  logic [2:0]      si_r, si_nxt;
  logic [ROW_W-1:0] vrow_r, vrow_nxt;
  logic [1:0]      c_r, c_nxt, c2_r, c2_nxt;
  logic [2:0]      ei_r, ei_nxt;
  logic [RSTART_W-1:0] rs_r, rs_nxt;
  logic            kwr;
  logic [2:0]      sort_k;

  // Point evaluation; selection 7 is the vertex itself, taken unwrapped for its
  // colour and row.
  logic [2:0]      psel;
  logic            p_ok;
  logic signed [19:0] p_off [3];
  logic [P_W-1:0]  p_crd [3];
  assign psel = pt_r;

  scar_point #(.SH_W(SH_W), .P_W(P_W)) u_point (
    .sh(sh), .st(st), .wd(wd), .wr(wr), .vp(vp_r), .sel(psel),
    .ok(p_ok), .off(p_off), .p(p_crd)
  );

  // Shared multiply-add: mul_a * mul_b + mul_c.
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] mul_c, mul_y;
  logic signed [17:0] c0, c1;
  assign c0 = 18'(signed'({1'b0, sh[0]})) - 18'(signed'({2'b0, wd[0]})) + 18'sd1;
  assign c1 = 18'(signed'({1'b0, sh[1]})) - 18'(signed'({2'b0, wd[1]})) + 18'sd1;
  assign mul_y = 50'(mul_a * mul_b) + mul_c;

  always_comb begin
    mul_a = '0; mul_b = '0; mul_c = '0;
    case (ph_r)
      2'd0: begin mul_a = 35'(p_off[2]); mul_b = c1; mul_c = 50'(p_off[1]); end
      2'd1: begin mul_a = 35'(acc_r); mul_b = c0; mul_c = 50'(p_off[0]); end
      2'd2: begin
        mul_a = 35'(signed'({1'b0, p_crd[2]})); mul_b = 18'(signed'({1'b0, sh[1]}));
        mul_c = 50'(signed'({1'b0, p_crd[1]}));
      end
      default: begin
        mul_a = 35'(acc_r); mul_b = 18'(signed'({1'b0, sh[0]}));
        mul_c = 50'(signed'({1'b0, p_crd[0]}));
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_NBR;
      ST_NBR:  if (ph_r == 2'd3 && pt_r == 3'd6) state_nxt = ST_SORT;
      ST_SORT: if (si_r == 3'd6) state_nxt = (nk_r == 3'd0 || bs_r == 2'd0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (out_ready && out_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    pt_nxt = pt_r; ph_nxt = ph_r; acc_nxt = acc_r; col_nxt = col_r; vcol_nxt = vcol_r;
    idx_nxt = idx_r; ok_nxt = ok_r; nk_nxt = nk_r; si_nxt = si_r; vrow_nxt = vrow_r;
    c_nxt = c_r; c2_nxt = c2_r; ei_nxt = ei_r; rs_nxt = rs_r; offs_nxt = offs_r;
    kwr = 1'b0; sort_k = 3'd0;
    case (state_r)
      ST_IDLE: if (in_valid) begin
        pt_nxt = 3'd7; ph_nxt = 2'd0; nk_nxt = 3'd0; si_nxt = 3'd0;
        if (in_restart) offs_nxt = '0;
      end
      ST_NBR: begin
        ph_nxt = ph_r + 2'd1;
        case (ph_r)
          2'd0: begin acc_nxt = mul_y; ok_nxt = p_ok; end
          2'd1: col_nxt = mul_y;
          2'd2: acc_nxt = mul_y;
          default: begin
            idx_nxt = 48'(mul_y);
            if (pt_r == 3'd7) begin
              vcol_nxt = col_r;
              vrow_nxt = ROW_W'(mul_y);
              pt_nxt = 3'd0;
            end else begin
              kwr = ok_r && (col_r == vcol_r);
              if (kwr) nk_nxt = nk_r + 3'd1;
              pt_nxt = pt_r + 3'd1;
            end
          end
        endcase
      end
      ST_SORT: begin
        // Odd-even transposition: 7 passes over at most 7 entries.
        si_nxt = si_r + 3'd1;
        sort_k = si_r;
        if (si_r == 3'd6) begin
          c_nxt = 2'd0; c2_nxt = 2'd0; ei_nxt = 3'd0;
          rs_nxt = offs_r[RSTART_W-1:0];
          vrow_nxt = ROW_W'(vrow_r * ROW_W'(bs_r));
        end
      end
      ST_EMIT: if (out_ready) begin
        offs_nxt = offs_r + OFFS_W'(1);
        if (c2_r == bs_r - 2'd1) begin
          c2_nxt = 2'd0;
          if (ei_r == nk_r - 3'd1) begin
            ei_nxt = 3'd0;
            c_nxt = c_r + 2'd1;
            rs_nxt = offs_nxt[RSTART_W-1:0];
          end else ei_nxt = ei_r + 3'd1;
        end else c2_nxt = c2_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      offs_r  <= '0;
    end else begin
      state_r <= state_nxt;
      offs_r  <= offs_nxt;
    end
  end

  // Payload registers; kept list filled in order, then sorted in place.
  always_ff @(posedge clk) begin
    pt_r <= pt_nxt; ph_r <= ph_nxt; acc_r <= acc_nxt; col_r <= col_nxt;
    vcol_r <= vcol_nxt; idx_r <= idx_nxt; ok_r <= ok_nxt; nk_r <= nk_nxt;
    si_r <= si_nxt; vrow_r <= vrow_nxt; c_r <= c_nxt; c2_r <= c2_nxt;
    ei_r <= ei_nxt; rs_r <= rs_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      vp_r[0] <= in_vertex_x; vp_r[1] <= in_vertex_y; vp_r[2] <= in_vertex_z;
    end
    if (kwr) kept_r[nk_r] <= idx_nxt;
    if (state_r == ST_SORT) begin
      for (int j = 0; j < NPTS - 1; j++) begin
        if ((j % 2) == int'(sort_k[0]) && (j + 1) < int'(nk_r)
            && kept_r[j] > kept_r[j+1]) begin
          kept_r[j]   <= kept_r[j+1];
          kept_r[j+1] <= kept_r[j];
        end
      end
    end
  end

  // Result outputs.
  logic end_row;
  assign end_row = (ei_r == nk_r - 3'd1) && (c2_r == bs_r - 2'd1);
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign out_row = vrow_r + ROW_W'(c_r);
  assign out_row_start = rs_r;
  assign out_column = ROW_W'(kept_r[ei_r]) * ROW_W'(bs_r) + ROW_W'(c2_r);
  assign out_last_in_row = end_row;
  assign out_last = end_row && (c_r == bs_r - 2'd1);

endmodule

FILE: bench/tb_stencil_color_adjacency_rows_core.sv
`timescale 1ns / 1ps
module tb_stencil_color_adjacency_rows_core;
  import scar_pkg::*;

  localparam int AXIS_LIMIT = 1024;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [ROW_W-1:0]    row;
    logic [RSTART_W-1:0] row_start;
    logic [ROW_W-1:0]    column;
    logic                last_in_row;
    logic                last;
  } adj_entry_t;

  localparam int DX [NPTS] = '{0, 0, -1, 0, 1, 0, 0};
  localparam int DY [NPTS] = '{0, -1, 0, 0, 0, 1, 0};
  localparam int DZ [NPTS] = '{-1, 0, 0, 0, 0, 0, 1};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = REG_AXIS_X;
  logic [GEOM_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CRD_W-1:0]    in_vertex_x = '0;
  logic [CRD_W-1:0]    in_vertex_y = '0;
  logic [CRD_W-1:0]    in_vertex_z = '0;
  logic                in_restart = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ROW_W-1:0]    out_row;
  logic [RSTART_W-1:0] out_row_start;
  logic [ROW_W-1:0]    out_column;
  logic                out_last_in_row;
  logic                out_last;

  // Predictor state: register copies and the running column offset.
  logic [GEOM_W-1:0]   geom_reg [3];
  logic [1:0]          block_reg;
  logic [OFFS_W-1:0]   col_offset;

  adj_entry_t          expected_entries [$];
  int                  failures = 0;
  bit                  idle_on = 1'b1;
  int                  ready_hold = 0;
  int                  quiet_cycles = 0;

  stencil_color_adjacency_rows_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y),
    .in_vertex_z(in_vertex_z), .in_restart(in_restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_row_start(out_row_start), .out_column(out_column),
    .out_last_in_row(out_last_in_row), .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Region color of a point from its offset outside the owned box.
  function automatic longint region_color(longint sh[3], longint st[3], longint wd[3],
                                          longint p[3]);
    longint off [3];
    longint c0, c1;
    for (int a = 0; a < 3; a++) begin
      off[a] = 0;
      if (p[a] < st[a]) off[a] = p[a] - st[a];
      if (p[a] > st[a] + wd[a] - 1) off[a] = p[a] - (st[a] + wd[a] - 1);
    end
    c0 = sh[0] - wd[0] + 1;
    c1 = sh[1] - wd[1] + 1;
    return off[0] + off[1] * c0 + off[2] * c0 * c1;
  endfunction

  // Compute the adjacency entries of one vertex and queue them.
  task automatic predict_rows(input logic [CRD_W-1:0] vx, vy, vz, input logic rs);
    longint sh [3], st [3], wd [3], vp [3], p [3];
    bit wr [3];
    longint kept [NPTS];
    longint t, vidx, rstart, bs, own_color;
    int nk, j;
    bit ok;
    adj_entry_t e;
    nk = 0;
    bs = block_reg;
    for (int a = 0; a < 3; a++) begin
      sh[a] = geom_reg[a][15:0];
      if (sh[a] > AXIS_LIMIT) sh[a] = AXIS_LIMIT;
      st[a] = geom_reg[a][31:16];
      wd[a] = geom_reg[a][47:32];
      wr[a] = geom_reg[a][48];
    end
    vp[0] = vx; vp[1] = vy; vp[2] = vz;
    if (rs) col_offset = '0;
    own_color = region_color(sh, st, wd, vp);
    for (int s = 0; s < NPTS; s++) begin
      ok = 1'b1;
      p[0] = vp[0] + DX[s]; p[1] = vp[1] + DY[s]; p[2] = vp[2] + DZ[s];
      for (int a = 0; a < 3; a++) begin
        if (wr[a]) begin
          if (p[a] < 0) p[a] += sh[a];
          else if (p[a] >= sh[a]) p[a] -= sh[a];
        end
        if (p[a] < 0 || p[a] >= sh[a]) ok = 1'b0;
      end
      if (ok && region_color(sh, st, wd, p) == own_color) begin
        kept[nk] = p[0] + p[1] * sh[0] + p[2] * sh[0] * sh[1];
        nk++;
      end
    end
    for (int i = 1; i < nk; i++) begin
      t = kept[i];
      j = i;
      while (j > 0 && kept[j-1] > t) begin
        kept[j] = kept[j-1];
        j--;
      end
      kept[j] = t;
    end
    if (nk == 0 || bs == 0) return;
    vidx = vp[0] + vp[1] * sh[0] + vp[2] * sh[0] * sh[1];
    for (longint c = 0; c < bs; c++) begin
      rstart = col_offset;
      for (int i = 0; i < nk; i++) begin
        for (longint c2 = 0; c2 < bs; c2++) begin
          e.row = ROW_W'(c + bs * vidx);
          e.row_start = RSTART_W'(rstart);
          e.column = ROW_W'(c2 + bs * kept[i]);
          e.last_in_row = (i == nk - 1) && (c2 == bs - 1);
          e.last = e.last_in_row && (c == bs - 1);
          expected_entries.push_back(e);
          col_offset = col_offset + 1'b1;
        end
      end
    end
  endtask

  // Present one vertex, optionally after an idle burst, and wait for the transfer.
  task automatic send_vertex(input logic [CRD_W-1:0] vx, vy, vz, input logic rs);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vertex_x <= vx;
    in_vertex_y <= vy;
    in_vertex_z <= vz;
    in_restart <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_rows(vx, vy, vz, rs);
  endtask

  // Let the block drain, then write all four registers back to back.
  task automatic load_geometry(input logic [GEOM_W-1:0] gx, gy, gz, bsz);
    logic [GEOM_W-1:0] vals [4];
    in_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    vals[0] = gx; vals[1] = gy; vals[2] = gz; vals[3] = bsz;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      if (i < 3) geom_reg[i] = vals[i];
      else block_reg = vals[i][1:0];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [GEOM_W-1:0] axis_word(int shape, int start, int width, bit wrap);
    return {wrap, 16'(width), 16'(start), 16'(shape)};
  endfunction

  task automatic test_reset_defaults();
    send_vertex('0, '0, '0, 1'b1);
    send_vertex('0, '0, '0, 1'b0);
    // Vertex far outside the unit grid keeps its raw coordinates.
    send_vertex('1, '1, '1, 1'b0);
  endtask

  task automatic test_directed();
    // Small owned box inside a 4x3x2 grid, block size 3.
    load_geometry(axis_word(4, 1, 2, 0), axis_word(3, 0, 2, 0), axis_word(2, 0, 1, 0), 3);
    send_vertex(0, 0, 0, 1'b1);
    send_vertex(1, 1, 0, 1'b0);
    send_vertex(3, 2, 1, 1'b0);
    send_vertex(2, 1, 1, 1'b0);
    // Periodic axes: shape 1 wraps every neighbour onto the vertex itself.
    load_geometry(axis_word(1, 0, 1, 1), axis_word(1, 0, 1, 1), axis_word(1, 0, 1, 1), 3);
    send_vertex(0, 0, 0, 1'b1);
    load_geometry(axis_word(5, 0, 5, 1), axis_word(4, 0, 4, 1), axis_word(3, 0, 3, 1), 2);
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(4, 3, 2, 1'b0);
    // Shape above the axis limit saturates.
    load_geometry(axis_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1),
                  axis_word(1025, 0, 1025, 0), axis_word(2, 0, 0, 0), 1);
    send_vertex('1, '1, 1, 1'b0);
    send_vertex(0, 0, 0, 1'b1);
    // Zero shape drops everything; zero block size gives no rows.
    load_geometry(axis_word(0, 0, 0, 1), axis_word(3, 0, 3, 0), axis_word(3, 0, 3, 0), 2);
    send_vertex(0, 1, 1, 1'b0);
    load_geometry(axis_word(3, 0, 3, 0), axis_word(3, 0, 3, 0), axis_word(3, 0, 3, 0), 0);
    send_vertex(1, 1, 1, 1'b0);
    load_geometry(axis_word(3, 0, 3, 0), axis_word(3, 0, 3, 0), axis_word(3, 0, 3, 0),
                  {{(GEOM_W-2){1'b1}}, 2'd1});
    send_vertex(1, 1, 1, 1'b0);
    send_vertex(2, 2, 2, 1'b0);
  endtask

  // Random phases: mostly raster sweeps over small grids, some noise.
  task automatic test_random_phases(input int phases);
    logic [GEOM_W-1:0] g [3];
    int shp [3];
    int total, k, mode;
    bit noise;
    for (int ph = 0; ph < phases; ph++) begin
      mode = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
        shp[a] = $urandom_range(1, 5);
        if (mode == 0) g[a] = GEOM_W'({$urandom, $urandom});
        else if (mode == 1 && a == 0) g[a] = axis_word(0, 0, 1, 1'($urandom_range(0, 1)));
        else g[a] = axis_word(shp[a], $urandom_range(0, shp[a]), $urandom_range(0, shp[a]),
                              1'($urandom_range(0, 1)));
      end
      load_geometry(g[0], g[1], g[2], GEOM_W'({$urandom, $urandom}));
      total = shp[0] * shp[1] * shp[2];
      k = 0;
      for (int n = 0; n < 29; n++) begin
        noise = (mode < 2) || ($urandom_range(0, 7) == 0);
        if (noise)
          send_vertex(CRD_W'($urandom), CRD_W'($urandom), CRD_W'($urandom),
                      1'($urandom_range(0, 1)));
        else begin
          send_vertex(CRD_W'(k % shp[0]), CRD_W'((k / shp[0]) % shp[1]),
                      CRD_W'(k / (shp[0] * shp[1])), k == 0);
          k = (k + 1) % total;
        end
      end
    end
  endtask

  // Result side: random stalls, none once idling is switched off.
  always @(posedge clk) begin
    if (idle_on && ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      ready_hold <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expected entry.
  always @(posedge clk) begin
    adj_entry_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_entries.size() == 0) begin
        $error("unexpected result: row %0d column %0d", out_row, out_column);
        failures++;
      end else begin
        e = expected_entries.pop_front();
        if (out_row !== e.row) begin
          $error("row expected %0d actual %0d", e.row, out_row);
          failures++;
        end
        if (out_row_start !== e.row_start) begin
          $error("row_start expected %0d actual %0d", e.row_start, out_row_start);
          failures++;
        end
        if (out_column !== e.column) begin
          $error("column expected %0d actual %0d", e.column, out_column);
          failures++;
        end
        if (out_last_in_row !== e.last_in_row) begin
          $error("last_in_row expected %0d actual %0d", e.last_in_row, out_last_in_row);
          failures++;
        end
        if (out_last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_last);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("stencil_color_adjacency_rows_core: mismatch");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a < 3; a++) geom_reg[a] = 49'd4294967297;
    block_reg = 2'd1;
    col_offset = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_phases(8);
    idle_on = 1'b0;
    test_random_phases(2);
    in_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("stencil_color_adjacency_rows_core: match");
    else
      $display("stencil_color_adjacency_rows_core: mismatch");
    $finish;
  end

endmodule

FILE: filelist.f
design/scar_pkg.sv
design/scar_point.sv
design/stencil_color_adjacency_rows_core.sv
bench/tb_stencil_color_adjacency_rows_core.sv
